// File: hw/rtl/srs_pkg.sv
// Shared types, constants and the helper function of the spin rotation step unit.
package srs_pkg;

    // Widths of the stream and configuration ports
    localparam int IN_DATA_W  = 224;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Field widths
    localparam int MAG_W  = 18;
    localparam int VEC_W  = 24;
    localparam int FLD_W  = 32;
    localparam int ACQ_W  = 16;
    localparam int SIDX_W = 16;

    // Shared multiplier lanes
    localparam int MUL_W  = 35;
    localparam int PROD_W = 70;

    // Iterations of the square root and of the axis divisions
    localparam int ROOT_STEPS = 31;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACQ_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_SEL = 2'd2;

    // Item kinds
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    // Arithmetic constants
    localparam logic [31:0] TIME_STEP_RESET = 32'd1048576;
    localparam logic [31:0] GAMMA_Q16       = 32'd1753337236;
    localparam logic [31:0] INV_2PI_Q32     = 32'd683565276;
    localparam logic [31:0] PI_HALF_Q30     = 32'd1686629713;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] ONE_Q30         = 32'd1073741824;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE, ST_DOT, ST_DOT_SUM, ST_GAMMA, ST_FIELD, ST_NORM, ST_SQUARE,
        ST_SQ_SUM, ST_SQRT, ST_DIV, ST_PROD, ST_TURN_MUL, ST_TURN, ST_Z_MUL,
        ST_CORDIC_INIT, ST_CORDIC, ST_QUAD, ST_CR_A, ST_CR_B, ST_CR_C,
        ST_DT_MUL, ST_DT, ST_T_MUL, ST_T, ST_F_A, ST_F_B, ST_F_C, ST_F_D, ST_FIN
    } srs_state_t;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_IDLE, OP_DOT, OP_DOT_SUM, OP_GAMMA, OP_FIELD, OP_NORM, OP_SQUARE,
        OP_SQ_SUM, OP_SQRT, OP_DIV, OP_PROD, OP_TURN_MUL, OP_TURN, OP_Z_MUL,
        OP_CORDIC_INIT, OP_CORDIC, OP_QUAD, OP_CR_A, OP_CR_B, OP_CR_C,
        OP_DT_MUL, OP_DT, OP_T_MUL, OP_T, OP_F_A, OP_F_B, OP_F_C, OP_F_D, OP_FIN
    } srs_op_t;

    typedef struct packed {
        srs_op_t    op;
        logic [4:0] iter;
    } srs_cmd_t;

    typedef struct packed {
        logic field_zero;
        logic emit_blocked;
    } srs_status_t;

    // Arctangent of 2^-i in radians, scaled to Q30
    function automatic logic [31:0] atan_step(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:    v = 32'd843314857;
            5'd1:    v = 32'd497837829;
            5'd2:    v = 32'd263043837;
            5'd3:    v = 32'd133525159;
            5'd4:    v = 32'd67021687;
            5'd5:    v = 32'd33543516;
            5'd6:    v = 32'd16775851;
            5'd7:    v = 32'd8388437;
            5'd8:    v = 32'd4194283;
            5'd9:    v = 32'd2097149;
            5'd10:   v = 32'd1048576;
            5'd31:   v = '0;
            default: v = 32'd1 << (5'd30 - i);
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/srs_ctrl.sv
// Sequencing controller of the spin rotation step unit.
module srs_ctrl #(
    parameter int CORDIC_ITERATIONS = 18
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_step,
    input  srs_pkg::srs_status_t status,
    output logic                in_ready,
    output srs_pkg::srs_cmd_t   cmd
);
    import srs_pkg::*;

    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_ITERATIONS - 1);
    localparam logic [4:0] ROOT_LAST   = 5'(ROOT_STEPS - 1);

    srs_state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       last;

    // Final pass of the current iterative phase
    assign last = (state_reg == ST_CORDIC) ? (cnt_reg == CORDIC_LAST)
                                           : (cnt_reg == ROOT_LAST);

    // State and iteration counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && (in_step == ACT_STEP))
                    state_next = ST_DOT;
            end
            ST_DOT:         state_next = ST_DOT_SUM;
            ST_DOT_SUM:     state_next = ST_GAMMA;
            ST_GAMMA:       state_next = ST_FIELD;
            ST_FIELD:       state_next = ST_NORM;
            ST_NORM:        state_next = status.field_zero ? ST_FIN : ST_SQUARE;
            ST_SQUARE:      state_next = ST_SQ_SUM;
            ST_SQ_SUM:      state_next = ST_SQRT;
            ST_SQRT:        state_next = last ? ST_DIV : ST_SQRT;
            ST_DIV:         state_next = last ? ST_PROD : ST_DIV;
            ST_PROD:        state_next = ST_TURN_MUL;
            ST_TURN_MUL:    state_next = ST_TURN;
            ST_TURN:        state_next = ST_Z_MUL;
            ST_Z_MUL:       state_next = ST_CORDIC_INIT;
            ST_CORDIC_INIT: state_next = ST_CORDIC;
            ST_CORDIC:      state_next = last ? ST_QUAD : ST_CORDIC;
            ST_QUAD:        state_next = ST_CR_A;
            ST_CR_A:        state_next = ST_CR_B;
            ST_CR_B:        state_next = ST_CR_C;
            ST_CR_C:        state_next = ST_DT_MUL;
            ST_DT_MUL:      state_next = ST_DT;
            ST_DT:          state_next = ST_T_MUL;
            ST_T_MUL:       state_next = ST_T;
            ST_T:           state_next = ST_F_A;
            ST_F_A:         state_next = ST_F_B;
            ST_F_B:         state_next = ST_F_C;
            ST_F_C:         state_next = ST_F_D;
            ST_F_D:         state_next = ST_FIN;
            ST_FIN:         state_next = status.emit_blocked ? ST_FIN : ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // Iteration counter of the square root, division and CORDIC phases
    always_comb
    begin
        if ((state_reg inside {ST_SQRT, ST_DIV, ST_CORDIC}) && !last)
            cnt_next = cnt_reg + 5'd1;
        else
            cnt_next = '0;
    end

    // Commands to the datapath
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        cmd.iter = cnt_reg;
        case (state_reg)
            ST_IDLE:        cmd.op = OP_IDLE;
            ST_DOT:         cmd.op = OP_DOT;
            ST_DOT_SUM:     cmd.op = OP_DOT_SUM;
            ST_GAMMA:       cmd.op = OP_GAMMA;
            ST_FIELD:       cmd.op = OP_FIELD;
            ST_NORM:        cmd.op = OP_NORM;
            ST_SQUARE:      cmd.op = OP_SQUARE;
            ST_SQ_SUM:      cmd.op = OP_SQ_SUM;
            ST_SQRT:        cmd.op = OP_SQRT;
            ST_DIV:         cmd.op = OP_DIV;
            ST_PROD:        cmd.op = OP_PROD;
            ST_TURN_MUL:    cmd.op = OP_TURN_MUL;
            ST_TURN:        cmd.op = OP_TURN;
            ST_Z_MUL:       cmd.op = OP_Z_MUL;
            ST_CORDIC_INIT: cmd.op = OP_CORDIC_INIT;
            ST_CORDIC:      cmd.op = OP_CORDIC;
            ST_QUAD:        cmd.op = OP_QUAD;
            ST_CR_A:        cmd.op = OP_CR_A;
            ST_CR_B:        cmd.op = OP_CR_B;
            ST_CR_C:        cmd.op = OP_CR_C;
            ST_DT_MUL:      cmd.op = OP_DT_MUL;
            ST_DT:          cmd.op = OP_DT;
            ST_T_MUL:       cmd.op = OP_T_MUL;
            ST_T:           cmd.op = OP_T;
            ST_F_A:         cmd.op = OP_F_A;
            ST_F_B:         cmd.op = OP_F_B;
            ST_F_C:         cmd.op = OP_F_C;
            ST_F_D:         cmd.op = OP_F_D;
            ST_FIN:         cmd.op = OP_FIN;
            default:        cmd.op = OP_IDLE;
        endcase
    end

endmodule

// File: hw/rtl/srs_datapath.sv
// Datapath of the spin rotation step unit: spin state, multiplier lanes, root, divide, CORDIC.
module srs_datapath #(
    parameter int STEP_COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  srs_pkg::srs_cmd_t                 cmd,
    output srs_pkg::srs_status_t              status,
    input  logic                              in_take,
    input  logic                              in_action,
    input  logic [srs_pkg::IN_DATA_W-1:0]     in_data,
    input  logic                              cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [srs_pkg::OUT_DATA_W-1:0]    out_data
);
    import srs_pkg::*;

    localparam int CMP_W = (STEP_COUNT_BITS + 1 > ACQ_W) ? STEP_COUNT_BITS + 1 : ACQ_W;

    // Configuration
    logic [31:0]      time_step_reg;
    logic [ACQ_W-1:0] acq_reg;
    logic             off_sel_reg;

    // Spin state
    logic signed [MAG_W-1:0]   mag_reg [3];
    logic signed [VEC_W-1:0]   pos_reg [3];
    logic signed [FLD_W-1:0]   spin_off_reg;
    logic [STEP_COUNT_BITS:0]  step_count_reg;

    // Step operands
    logic signed [VEC_W-1:0] grad_reg [3];
    logic signed [FLD_W-1:0] rfx_reg, rfy_reg, step_off_reg;

    // Working registers
    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [PROD_W-1:0] acc_reg  [3];
    logic signed [33:0]       dotsh_reg;
    logic signed [38:0]       w2_reg;
    logic [29:0]              ash_reg [3];
    logic                     sgn_reg [3];
    logic [4:0]               s_reg;
    logic [61:0]              rad_reg;
    logic [30:0]              root_reg;
    logic [33:0]              srem_reg;
    logic [31:0]              drem_reg [3];
    logic [30:0]              quo_reg  [3];
    logic [31:0]              turns_reg;
    logic [1:0]               quad_reg;
    logic signed [33:0]       x_reg, y_reg, z_reg, c_reg, sn_reg;
    logic signed [23:0]       cr_reg [3];
    logic signed [23:0]       dt_reg, t_reg;
    logic                     out_valid_reg;
    logic [OUT_DATA_W-1:0]    out_data_reg;

    // Combinational helpers
    logic signed [MUL_W-1:0]  mul_a [3];
    logic signed [MUL_W-1:0]  mul_b [3];
    logic signed [31:0]       n_ax [3];
    logic signed [MUL_W-1:0]  omc;
    logic signed [PROD_W-1:0] psum;
    logic signed [39:0]       wext [3];
    logic [38:0]              wabs [3];
    logic [38:0]              mx;
    logic [4:0]               s_sel;
    logic [35:0]              srem_t, trial;
    logic                     sq_ge;
    logic                     dv_ge [3];
    logic [31:0]              dv_rem [3];
    logic [95:0]              full_turn, shifted;
    logic [5:0]               k_sh;
    logic signed [33:0]       dx, dy, atan_v;
    logic signed [PROD_W-1:0] rnd [3];
    logic signed [MAG_W-1:0]  sat [3];
    logic                     emit, fin_go;
    logic [CMP_W-1:0]         diff;

    // Unit axis with the sign of the field
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            n_ax[i] = sgn_reg[i] ? -$signed({1'b0, quo_reg[i]}) : $signed({1'b0, quo_reg[i]});
        omc  = $signed(MUL_W'(ONE_Q30)) - MUL_W'(c_reg);
        psum = prod_reg[0] + prod_reg[1] + prod_reg[2];
    end

    // Field magnitudes and normalising shift
    always_comb
    begin
        wext[0] = 40'(rfx_reg);
        wext[1] = 40'(rfy_reg);
        wext[2] = 40'(w2_reg);
        mx = '0;
        for (int i = 0; i < 3; i++)
        begin
            wabs[i] = (wext[i] < 0) ? 39'(-wext[i]) : 39'(wext[i]);
            if (wabs[i] > mx)
                mx = wabs[i];
        end
        s_sel = '0;
        for (int k = 16; k >= 0; k--)
        begin
            if ((mx >> k) < 39'd1073741824)
                s_sel = 5'(k);
        end
    end

    // One digit of the square root and of each axis division
    always_comb
    begin
        srem_t = {srem_reg, rad_reg[61:60]};
        trial  = {3'b000, root_reg, 2'b01};
        sq_ge  = (srem_t >= trial);
        for (int i = 0; i < 3; i++)
        begin
            dv_ge[i]  = (drem_reg[i] >= {1'b0, root_reg});
            dv_rem[i] = dv_ge[i] ? (drem_reg[i] - {1'b0, root_reg}) : drem_reg[i];
        end
    end

    // Rotation angle in turns, CORDIC step terms and rounding of the result
    always_comb
    begin
        full_turn = 96'(prod_reg[0][61:0]) + (96'(prod_reg[1][60:0]) << 32);
        k_sh      = 6'd48 - 6'(s_reg);
        shifted   = full_turn >> k_sh;
        dx        = y_reg >>> cmd.iter;
        dy        = x_reg >>> cmd.iter;
        atan_v    = $signed(34'(atan_step(cmd.iter)));
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = (acc_reg[i] + prod_reg[i] + 70'sd536870912) >>> 30;
            if (rnd[i] > 70'sd131071)
                sat[i] = 18'sd131071;
            else if (rnd[i] < -70'sd131072)
                sat[i] = -18'sd131072;
            else
                sat[i] = MAG_W'(rnd[i]);
        end
    end

    // Multiplier operand selection
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mul_a[i] = '0;
            mul_b[i] = '0;
        end
        case (cmd.op)
            OP_DOT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_a[i] = MUL_W'(pos_reg[i]);
                    mul_b[i] = MUL_W'(grad_reg[i]);
                end
            end
            OP_GAMMA:
            begin
                mul_a[0] = MUL_W'(dotsh_reg);
                mul_b[0] = MUL_W'(GAMMA_Q16);
            end
            OP_SQUARE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_a[i] = MUL_W'(ash_reg[i]);
                    mul_b[i] = MUL_W'(ash_reg[i]);
                end
            end
            OP_PROD:
            begin
                mul_a[0] = MUL_W'(root_reg);
                mul_b[0] = MUL_W'(time_step_reg);
            end
            OP_TURN_MUL:
            begin
                mul_a[0] = MUL_W'(prod_reg[0][31:0]);
                mul_a[1] = MUL_W'(prod_reg[0][62:32]);
                mul_b[0] = MUL_W'(INV_2PI_Q32);
                mul_b[1] = MUL_W'(INV_2PI_Q32);
            end
            OP_Z_MUL:
            begin
                mul_a[0] = MUL_W'(turns_reg[29:0]);
                mul_b[0] = MUL_W'(PI_HALF_Q30);
            end
            OP_CR_A:
            begin
                mul_a[0] = MUL_W'(n_ax[1]); mul_b[0] = MUL_W'(mag_reg[2]);
                mul_a[1] = MUL_W'(n_ax[2]); mul_b[1] = MUL_W'(mag_reg[0]);
                mul_a[2] = MUL_W'(n_ax[0]); mul_b[2] = MUL_W'(mag_reg[1]);
            end
            OP_CR_B:
            begin
                mul_a[0] = MUL_W'(n_ax[2]); mul_b[0] = MUL_W'(mag_reg[1]);
                mul_a[1] = MUL_W'(n_ax[0]); mul_b[1] = MUL_W'(mag_reg[2]);
                mul_a[2] = MUL_W'(n_ax[1]); mul_b[2] = MUL_W'(mag_reg[0]);
            end
            OP_DT_MUL:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_a[i] = MUL_W'(n_ax[i]);
                    mul_b[i] = MUL_W'(mag_reg[i]);
                end
            end
            OP_T_MUL:
            begin
                mul_a[0] = omc;
                mul_b[0] = MUL_W'(dt_reg);
            end
            OP_F_A:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_a[i] = MUL_W'(c_reg);
                    mul_b[i] = MUL_W'(mag_reg[i]);
                end
            end
            OP_F_B:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_a[i] = MUL_W'(sn_reg);
                    mul_b[i] = MUL_W'(cr_reg[i]);
                end
            end
            OP_F_C:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mul_a[i] = MUL_W'(t_reg);
                    mul_b[i] = MUL_W'(n_ax[i]);
                end
            end
            default:
            begin
                mul_a[0] = '0;
            end
        endcase
    end

    // Acquisition window and output slot
    assign diff   = CMP_W'(step_count_reg) - CMP_W'(acq_reg);
    assign emit   = !step_count_reg[STEP_COUNT_BITS] &&
                    (CMP_W'(step_count_reg) >= CMP_W'(acq_reg));
    assign fin_go = (cmd.op == OP_FIN) && !status.emit_blocked;

    always_comb
    begin
        status.field_zero   = (rfx_reg == '0) && (rfy_reg == '0) && (w2_reg == '0);
        status.emit_blocked = emit && out_valid_reg && !out_ready;
    end

    // Configuration, spin state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg  <= TIME_STEP_RESET;
            acq_reg        <= '0;
            off_sel_reg    <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= '0;
                pos_reg[i] <= '0;
            end
            spin_off_reg   <= '0;
            step_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TIME_STEP:  time_step_reg <= cfg_data;
                    CFG_ACQ_START:  acq_reg       <= cfg_data[ACQ_W-1:0];
                    CFG_OFFSET_SEL: off_sel_reg   <= cfg_data[0];
                    default:        off_sel_reg   <= off_sel_reg;
                endcase
            end
            if (in_take && (in_action == ACT_LOAD))
            begin
                mag_reg[0]     <= in_data[17:0];
                mag_reg[1]     <= in_data[35:18];
                mag_reg[2]     <= in_data[53:36];
                pos_reg[0]     <= in_data[77:54];
                pos_reg[1]     <= in_data[101:78];
                pos_reg[2]     <= in_data[125:102];
                spin_off_reg   <= in_data[221:190];
                step_count_reg <= '0;
            end
            if (cmd.op == OP_F_D)
            begin
                for (int i = 0; i < 3; i++)
                    mag_reg[i] <= sat[i];
            end
            if (fin_go && !step_count_reg[STEP_COUNT_BITS])
                step_count_reg <= step_count_reg + 1'b1;
            if (fin_go && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers of the step computation
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            prod_reg[i] <= PROD_W'(mul_a[i]) * PROD_W'(mul_b[i]);

        if (in_take && (in_action == ACT_STEP))
        begin
            grad_reg[0]  <= in_data[77:54];
            grad_reg[1]  <= in_data[101:78];
            grad_reg[2]  <= in_data[125:102];
            rfx_reg      <= in_data[157:126];
            rfy_reg      <= in_data[189:158];
            step_off_reg <= in_data[221:190];
        end

        if (fin_go && emit)
            out_data_reg <= {2'b00, diff[SIDX_W-1:0], mag_reg[2], mag_reg[1], mag_reg[0]};

        case (cmd.op)
            OP_DOT_SUM: dotsh_reg <= 34'(psum >>> 16);
            OP_FIELD:   w2_reg <= 39'(prod_reg[0] >>> 28)
                                  + 39'(off_sel_reg ? step_off_reg : spin_off_reg);
            OP_NORM:
            begin
                s_reg <= s_sel;
                for (int i = 0; i < 3; i++)
                begin
                    ash_reg[i] <= 30'(wabs[i] >> s_sel);
                    sgn_reg[i] <= (wext[i] < 0);
                end
            end
            OP_SQ_SUM:
            begin
                rad_reg  <= 62'(psum);
                root_reg <= '0;
                srem_reg <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[i] <= 32'(ash_reg[i]);
                    quo_reg[i]  <= '0;
                end
            end
            OP_SQRT:
            begin
                rad_reg  <= rad_reg << 2;
                srem_reg <= 34'(sq_ge ? (srem_t - trial) : srem_t);
                root_reg <= {root_reg[29:0], sq_ge};
            end
            OP_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    drem_reg[i] <= {dv_rem[i][30:0], 1'b0};
                    quo_reg[i]  <= {quo_reg[i][29:0], dv_ge[i]};
                end
            end
            OP_TURN: turns_reg <= 32'd0 - shifted[31:0];
            OP_CORDIC_INIT:
            begin
                z_reg    <= 34'(prod_reg[0] >>> 30);
                x_reg    <= 34'(CORDIC_GAIN_Q30);
                y_reg    <= '0;
                quad_reg <= turns_reg[31:30];
            end
            OP_CORDIC:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_v;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_v;
                end
            end
            OP_QUAD:
            begin
                case (quad_reg)
                    2'd0:    begin c_reg <= x_reg;  sn_reg <= y_reg;  end
                    2'd1:    begin c_reg <= -y_reg; sn_reg <= x_reg;  end
                    2'd2:    begin c_reg <= -x_reg; sn_reg <= -y_reg; end
                    default: begin c_reg <= y_reg;  sn_reg <= -x_reg; end
                endcase
            end
            OP_CR_B, OP_F_B:
            begin
                for (int i = 0; i < 3; i++)
                    acc_reg[i] <= prod_reg[i];
            end
            OP_CR_C:
            begin
                for (int i = 0; i < 3; i++)
                    cr_reg[i] <= 24'((acc_reg[i] - prod_reg[i]) >>> 30);
            end
            OP_DT: dt_reg <= 24'(psum >>> 30);
            OP_T:  t_reg  <= 24'(prod_reg[0] >>> 30);
            OP_F_C:
            begin
                for (int i = 0; i < 3; i++)
                    acc_reg[i] <= acc_reg[i] + prod_reg[i];
            end
            default:
            begin
                dotsh_reg <= dotsh_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: hw/rtl/spin_rotation_step_unit.sv
// A load item is taken without leaving the idle state; a step item holds ready low from
// acceptance until its work is done, through the square root, the axis division and the
// CORDIC loop; a step with zero field skips these phases.
// Throughput: one item at a time; a result waits in an output register and stalls only
// the final state (ST_FIN) of the next emitting step.
// Reset: asynchronous active low; clears the spin state and step count, reloads the registers.
module spin_rotation_step_unit #(
    parameter int STEP_COUNT_BITS   = 16,
    parameter int CORDIC_ITERATIONS = 18
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mag_x, mag_y, mag_z, vec_x, vec_y, vec_z, rf_x, rf_y, off_resonance, zero fill
    input  logic [srs_pkg::IN_DATA_W-1:0]  s_tdata,
    // action
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_mx, out_my, out_mz, sample_index, zero fill
    output logic [srs_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_we,
    input  logic [srs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import srs_pkg::*;

    srs_cmd_t    cmd;
    srs_status_t status;
    logic        take;

    // An item is taken when both sides of the input handshake agree
    assign take = s_tvalid && s_tready;

    srs_ctrl #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_step  (s_tuser),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    srs_datapath #(
        .STEP_COUNT_BITS(STEP_COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_take   (take),
        .in_action (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // A step item occupies the block until its work is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && (s_tuser == ACT_STEP)) |=> !s_tready)
        else $error("input ready while a step item is in progress");

    // A load item completes at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && (s_tuser == ACT_LOAD)) |=> s_tready)
        else $error("load item did not complete in one cycle");

    // A new result appears only at the end of a step item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result item raised outside the end of a step");

    // A zero-field step never enters the root or division phases.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == OP_NORM) && status.field_zero) |=> (cmd.op == OP_FIN))
        else $error("zero field did not skip the rotation");

endmodule

// File: verif/tb_spin_rotation_step_unit.sv
// Self-checking testbench of the spin rotation step unit with its own rotation predictor.
module tb_spin_rotation_step_unit;

    import srs_pkg::*;

    localparam int COUNT_BITS   = 16;
    localparam int CORDIC_ITERS = 18;
    localparam int STEP_LATENCY = 88 + CORDIC_ITERS;
    localparam int WATCHDOG_MAX = 20000;
    localparam int HOLD_OFF_LEN = 2000;

    // Scoreboard: predicts the rotated magnetization of each step item.
    class spin_scoreboard;
        longint          mag_state[3];
        longint          pos_state[3];
        longint          offset_state;
        longint unsigned step_cnt;
        bit [31:0]       time_step;
        bit [15:0]       acq_from;
        bit              offset_sel;
        bit [69:0]       sample_q[$];
        int              errors;
        longint          atan_q30[11] = '{843314857, 497837829, 263043837, 133525159,
                                          67021687, 33543516, 16775851, 8388437,
                                          4194283, 2097149, 1048576};

        function new();
            errors = 0;
            for (int i = 0; i < 3; i++)
            begin
                mag_state[i] = 0;
                pos_state[i] = 0;
            end
            offset_state = 0;
            step_cnt     = 0;
            time_step    = TIME_STEP_RESET;
            acq_from     = '0;
            offset_sel   = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_TIME_STEP)
                time_step = val;
            else if (idx == CFG_ACQ_START)
                acq_from = val[15:0];
            else if (idx == CFG_OFFSET_SEL)
                offset_sel = val[0];
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // Cosine and sine of a 32-bit turn fraction by quadrant split and CORDIC.
        function void turn_sincos(bit [31:0] turns, output longint c, output longint sn);
            longint x;
            longint y;
            longint z;
            longint dx;
            longint dy;
            longint ang;
            bit [63:0] r;
            r  = {34'd0, turns[29:0]};
            z  = longint'((r * longint'(PI_HALF_Q30)) >> 30);
            x  = longint'(CORDIC_GAIN_Q30);
            y  = 0;
            for (int i = 0; i < CORDIC_ITERS && i < 32; i++)
            begin
                dx  = y >>> i;
                dy  = x >>> i;
                ang = (i < 11) ? atan_q30[i] : ((i <= 30) ? (longint'(1) << (30 - i)) : 0);
                if (z >= 0)
                begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ang;
                end
                else
                begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ang;
                end
            end
            case (turns[31:30])
                2'd0:    begin c = x;  sn = y;  end
                2'd1:    begin c = -y; sn = x;  end
                2'd2:    begin c = -x; sn = -y; end
                default: begin c = y;  sn = -x; end
            endcase
        endfunction

        // Rodrigues rotation of the magnetization about the field by -|W| * time_step.
        function void rotate_mag(longint fld[3]);
            longint unsigned a[3];
            longint unsigned amax;
            longint unsigned sq;
            longint unsigned norm;
            bit [63:0] p, pl, ph, lo, mid, lw, hw, turns;
            int        s;
            int        k;
            longint    ax[3];
            longint    cr[3];
            longint    res[3];
            longint    c;
            longint    sn;
            longint    dt;
            longint    t;
            longint    acc;
            amax = 0;
            sq   = 0;
            s    = 0;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = (fld[i] < 0) ? longint'(-fld[i]) : longint'(fld[i]);
                if (a[i] > amax)
                    amax = a[i];
            end
            if (amax == 0)
                return;
            while (s < 16 && (amax >> s) >= (64'd1 << 30))
                s++;
            for (int i = 0; i < 3; i++)
            begin
                a[i] = a[i] >> s;
                sq   = sq + a[i] * a[i];
            end
            norm = int_sqrt(sq);
            for (int i = 0; i < 3; i++)
            begin
                ax[i] = longint'((a[i] << 30) / norm);
                if (fld[i] < 0)
                    ax[i] = -ax[i];
            end

            // Turn angle with the exact 96-bit product kept in two words
            p     = norm * {32'd0, time_step};
            pl    = p & 64'hFFFF_FFFF;
            ph    = p >> 32;
            lo    = pl * {32'd0, INV_2PI_Q32};
            mid   = ph * {32'd0, INV_2PI_Q32};
            lw    = lo + (mid << 32);
            hw    = (mid >> 32) + ((lw < lo) ? 64'd1 : 64'd0);
            k     = 48 - s;
            turns = ((hw << (64 - k)) | (lw >> k)) & 64'hFFFF_FFFF;
            turns = (64'd0 - turns) & 64'hFFFF_FFFF;
            turn_sincos(turns[31:0], c, sn);

            cr[0] = (ax[1] * mag_state[2] - ax[2] * mag_state[1]) >>> 30;
            cr[1] = (ax[2] * mag_state[0] - ax[0] * mag_state[2]) >>> 30;
            cr[2] = (ax[0] * mag_state[1] - ax[1] * mag_state[0]) >>> 30;
            dt    = (ax[0] * mag_state[0] + ax[1] * mag_state[1] + ax[2] * mag_state[2]) >>> 30;
            t     = ((longint'(ONE_Q30) - c) * dt) >>> 30;
            for (int i = 0; i < 3; i++)
            begin
                acc    = c * mag_state[i] + sn * cr[i] + t * ax[i];
                res[i] = (acc + (longint'(1) << 29)) >>> 30;
                if (res[i] > 131071)
                    res[i] = 131071;
                if (res[i] < -131072)
                    res[i] = -131072;
            end
            for (int i = 0; i < 3; i++)
                mag_state[i] = res[i];
        endfunction

        // Notes an accepted input item and queues the sample it produces, if any.
        function void note_item(bit act, bit [IN_DATA_W-1:0] d);
            longint          vec[3];
            longint          fld[3];
            longint          dotp;
            longint          off;
            longint unsigned idx;
            bit [15:0]       sidx;
            vec[0] = longint'($signed(d[77:54]));
            vec[1] = longint'($signed(d[101:78]));
            vec[2] = longint'($signed(d[125:102]));
            off    = longint'($signed(d[221:190]));
            if (act == ACT_LOAD)
            begin
                mag_state[0] = longint'($signed(d[17:0]));
                mag_state[1] = longint'($signed(d[35:18]));
                mag_state[2] = longint'($signed(d[53:36]));
                for (int i = 0; i < 3; i++)
                    pos_state[i] = vec[i];
                offset_state = off;
                step_cnt     = 0;
                return;
            end
            dotp = 0;
            for (int i = 0; i < 3; i++)
                dotp = dotp + pos_state[i] * vec[i];
            if (!offset_sel)
                off = offset_state;
            fld[0] = longint'($signed(d[157:126]));
            fld[1] = longint'($signed(d[189:158]));
            fld[2] = (((dotp >>> 16) * longint'(GAMMA_Q16)) >>> 28) + off;
            rotate_mag(fld);
            idx = step_cnt;
            if (step_cnt < (64'd1 << COUNT_BITS))
                step_cnt++;
            if (idx >= (64'd1 << COUNT_BITS) || idx < acq_from)
                return;
            sidx = 16'(idx - acq_from);
            sample_q.push_back({sidx, mag_state[2][17:0], mag_state[1][17:0],
                                mag_state[0][17:0]});
        endfunction

        // Compares an emitted sample with the oldest prediction.
        function void check_result(bit [OUT_DATA_W-1:0] d);
            bit [69:0] want;
            string     names[4] = '{"out_mx", "out_my", "out_mz", "sample_index"};
            int        lsb[4]   = '{0, 18, 36, 54};
            int        wid[4]   = '{18, 18, 18, 16};
            bit [17:0] w_f;
            bit [17:0] g_f;
            if (sample_q.size() == 0)
            begin
                $display("%0t: unexpected sample, expected none, actual %h", $time, d);
                errors++;
                return;
            end
            want = sample_q.pop_front();
            for (int f = 0; f < 4; f++)
            begin
                w_f = 18'((want >> lsb[f]) & ((18'd1 << wid[f]) - 1));
                g_f = 18'((d >> lsb[f]) & ((18'd1 << wid[f]) - 1));
                if (w_f != g_f)
                begin
                    $display("%0t: %s mismatch, expected %h, actual %h",
                             $time, names[f], w_f, g_f);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    spin_scoreboard sb = new();
    bit             hold_req = 1'b0;
    int             burst_left = 0;
    int             idle_cycles = 0;

    spin_rotation_step_unit #(
        .STEP_COUNT_BITS   (COUNT_BITS),
        .CORDIC_ITERATIONS (CORDIC_ITERS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
            #2 clk = ~clk;
    end

    // Output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Watchdog on cycles without any accepted item or register write
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver stall pattern, with one long hold-off on request
    initial
    begin
        int mode;
        int len;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(1, 300);
            repeat (len)
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Field value biased towards the extremes of a signed field
    function automatic bit [31:0] pick_field(int w);
        bit [31:0] mask;
        mask = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 1);
        case ($urandom_range(0, 7))
            0:       return (32'd1 << (w - 1)) & mask;
            1:       return ((32'd1 << (w - 1)) - 1) & mask;
            2:       return '0;
            3:       return $urandom_range(0, 255) & mask;
            4:       return (-$urandom_range(0, 255)) & mask;
            default: return $urandom & mask;
        endcase
    endfunction

    function automatic bit [IN_DATA_W-1:0] pack_item(
        bit [17:0] mx, bit [17:0] my, bit [17:0] mz,
        bit [23:0] vx, bit [23:0] vy, bit [23:0] vz,
        bit [31:0] rx, bit [31:0] ry, bit [31:0] off);
        return {2'b00, off, ry, rx, vz, vy, vx, mz, my, mx};
    endfunction

    function automatic bit [IN_DATA_W-1:0] random_item();
        return pack_item(pick_field(18), pick_field(18), pick_field(18),
                         pick_field(24), pick_field(24), pick_field(24),
                         pick_field(32), pick_field(32), pick_field(32));
    endfunction

    // Offers one item, waits for its acceptance and inserts sender gaps between bursts
    task automatic send_item(bit act, bit [IN_DATA_W-1:0] d, bit bursty);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= d;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(act, d);
        if (bursty)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 150)) @(posedge clk);
                burst_left = $urandom_range(1, 20);
            end
            else
                burst_left--;
        end
    endtask

    // One register write; the write port is then left quiet before the task returns
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Lets the block finish its work once every predicted sample has arrived
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.sample_q.size() != 0)
            @(posedge clk);
        repeat (STEP_LATENCY + 20) @(posedge clk);
    endtask

    // Random sequences: mostly a load followed by steps, the rest loose items
    task automatic run_random(int n_items, bit with_hold);
        int          sent;
        int          n_steps;
        bit          hold_done;
        bit [IN_DATA_W-1:0] d;
        sent      = 0;
        hold_done = 1'b0;
        while (sent < n_items)
        begin
            if (with_hold && !hold_done && sent >= n_items / 2)
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 99) < 85)
            begin
                d = random_item();
                if ($urandom_range(0, 1))
                    d[53:0] = {18'($signed($urandom_range(0, 131072) - 65536)),
                               18'($signed($urandom_range(0, 131072) - 65536)),
                               18'($signed($urandom_range(0, 131072) - 65536))};
                send_item(ACT_LOAD, d, 1'b1);
                sent++;
                n_steps = $urandom_range(1, 12);
                repeat (n_steps)
                begin
                    d = random_item();
                    if ($urandom_range(0, 3) == 0)
                        d[125:54] = '0;
                    send_item(ACT_STEP, d, 1'b1);
                    sent++;
                end
            end
            else
            begin
                send_item(1'($urandom_range(0, 1)), random_item(), 1'b1);
                sent++;
            end
        end
        settle();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset configuration
        send_item(ACT_STEP, pack_item(0, 0, 0, 24'h7FFFFF, 0, 0, 32'h1000, 0, 0), 1'b0);
        send_item(ACT_LOAD, pack_item(18'h1FFFF, 18'h20000, 0, 24'h7FFFFF, 24'h800000,
                                      24'h7FFFFF, 0, 0, 0), 1'b0);
        send_item(ACT_STEP, pack_item(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        send_item(ACT_STEP, pack_item(0, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 0), 1'b0);
        send_item(ACT_STEP, pack_item(0, 0, 0, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                                      0, 0, 0), 1'b0);
        send_item(ACT_STEP, pack_item(0, 0, 0, 24'h800000, 24'h7FFFFF, 24'h800000,
                                      32'h80000000, 32'h7FFFFFFF, 0), 1'b0);
        send_item(ACT_LOAD, pack_item(18'h20000, 18'h1FFFF, 18'h10000, 24'h800000,
                                      24'h800000, 24'h800000, 0, 0, 32'h7FFFFFFF), 1'b0);
        send_item(ACT_STEP, pack_item(0, 0, 0, 24'h800000, 24'h800000, 24'h800000,
                                      0, 0, 0), 1'b0);
        send_item(ACT_LOAD, pack_item(0, 0, 18'h10000, 0, 0, 0, 0, 0, 32'h80000000), 1'b0);
        send_item(ACT_STEP, pack_item(0, 0, 0, 0, 0, 0, 1, 0, 0), 1'b0);
        send_item(ACT_STEP, pack_item(0, 0, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0), 1'b0);
        settle();

        // Offset taken from each step item, longest step, late acquisition
        write_reg(CFG_OFFSET_SEL, 32'd1);
        write_reg(CFG_TIME_STEP, 32'hFFFFFFFF);
        write_reg(CFG_ACQ_START, 32'd2);
        send_item(ACT_LOAD, pack_item(18'h10000, 0, 0, 24'h010000, 0, 0, 0, 0, 0), 1'b0);
        send_item(ACT_STEP, pack_item(0, 0, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF), 1'b0);
        send_item(ACT_STEP, pack_item(0, 0, 0, 0, 0, 0, 0, 0, 32'h80000000), 1'b0);
        send_item(ACT_STEP, pack_item(0, 0, 0, 0, 0, 0, 0, 0, 32'h00000100), 1'b0);
        send_item(ACT_STEP, pack_item(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        settle();
        run_random(600, 1'b1);

        // Shortest nonzero step, per-spin offset
        write_reg(CFG_TIME_STEP, 32'd1);
        write_reg(CFG_ACQ_START, 32'd0);
        write_reg(CFG_OFFSET_SEL, 32'd0);
        run_random(500, 1'b0);

        // Zero step duration and an acquisition start never reached
        write_reg(CFG_TIME_STEP, 32'd0);
        write_reg(CFG_ACQ_START, 32'd65535);
        write_reg(CFG_OFFSET_SEL, 32'd1);
        run_random(100, 1'b0);

        // Random settings
        write_reg(CFG_TIME_STEP, $urandom);
        write_reg(CFG_ACQ_START, $urandom_range(0, 6));
        write_reg(CFG_OFFSET_SEL, $urandom_range(0, 1));
        run_random(400, 1'b0);
        write_reg(CFG_TIME_STEP, $urandom_range(1, 32'h00400000));
        write_reg(CFG_ACQ_START, $urandom_range(0, 3));
        write_reg(CFG_OFFSET_SEL, $urandom_range(0, 1));
        run_random(400, 1'b0);

        if (sb.errors == 0 && sb.sample_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
